### src/lsbq_pkg.sv
package lsbq_pkg;

    // coefficient format and digit-serial multiply geometry
    localparam int COEF_W     = 32;
    localparam int GUARD_BITS = 8;
    localparam int DIG_W      = 4;
    localparam int NUM_DIG    = COEF_W / DIG_W;
    localparam int DIG_CNT_W  = $clog2(NUM_DIG);
    localparam int NUM_TERMS  = 3;
    localparam int TERM_W     = 2;
    localparam int REG_IDX_W  = 3;

    localparam logic [DIG_CNT_W-1:0] LAST_DIG  = DIG_CNT_W'(NUM_DIG - 1);
    localparam logic [TERM_W-1:0]    LAST_TERM = TERM_W'(NUM_TERMS - 1);

    // b0 = 1.0 after reset, everything else zero
    localparam logic [COEF_W-1:0] FF_COEF0_RST = 32'h1000_0000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FF_COEF0 = 3'd0,
        REG_FF_COEF1 = 3'd1,
        REG_FF_COEF2 = 3'd2,
        REG_FB_COEF1 = 3'd3,
        REG_FB_COEF2 = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC_W,
        ST_FIN_W,
        ST_MAC_Y,
        ST_FIN_Y
    } t_state;

    typedef struct packed {
        logic              load;     // clear accumulator, load coefficient shifters
        logic              step;     // one digit-times-value accumulate
        logic              phase_y;  // 1: feedforward pass (add), 0: feedback pass (subtract)
        logic              msd;      // current digit is the signed top digit
        logic [TERM_W-1:0] term;     // which product term this cycle
        logic              fin_w;    // round/saturate w
        logic              fin_y;    // round/saturate y
    } t_mac_ctrl;

endpackage

### src/lsbq_in_if.sv
interface lsbq_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

### src/lsbq_out_if.sv
interface lsbq_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          clipped;

    modport source (output valid, output out_sample, output clipped, input ready);
    modport sink   (input valid, input out_sample, input clipped, output ready);
endinterface

### src/lsbq_mac.sv
module lsbq_mac
    import lsbq_pkg::*;
#(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28,
    parameter int STATE_BITS     = 48
) (
    input  logic                          i_clk,
    input  t_mac_ctrl                     i_ctrl,
    input  logic [COEF_W-1:0]             i_ff_coef0,
    input  logic [COEF_W-1:0]             i_ff_coef1,
    input  logic [COEF_W-1:0]             i_ff_coef2,
    input  logic [COEF_W-1:0]             i_fb_coef1,
    input  logic [COEF_W-1:0]             i_fb_coef2,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [STATE_BITS-1:0]  i_w,
    input  logic signed [STATE_BITS-1:0]  i_d1,
    input  logic signed [STATE_BITS-1:0]  i_d2,
    output logic signed [STATE_BITS-1:0]  o_w,
    output logic                          o_w_clip,
    output logic signed [SAMPLE_BITS-1:0] o_y,
    output logic                          o_y_clip
);

    localparam int WF     = STATE_BITS - SAMPLE_BITS - GUARD_BITS;
    localparam int YSH    = WF + COEF_FRAC_BITS;
    localparam int ACC_W  = STATE_BITS + COEF_W + 2;
    localparam int PROD_W = STATE_BITS + DIG_W + 1;

    logic signed [ACC_W-1:0]      r_acc;
    logic signed [ACC_W-1:0]      n_acc;
    logic [COEF_W-1:0]            r_sh [NUM_TERMS];

    logic signed [STATE_BITS-1:0] v_sel;
    logic [DIG_W-1:0]             dig;
    logic signed [DIG_W:0]        dig5;
    logic signed [PROD_W-1:0]     prod;
    logic signed [ACC_W-1:0]      prod_ext;
    logic signed [ACC_W-1:0]      acc_base;

    logic signed [ACC_W-1:0]      t_w;
    logic signed [ACC_W-1:0]      t_y;
    logic [ACC_W-COEF_FRAC_BITS-STATE_BITS:0] w_hi;
    logic [ACC_W-YSH-SAMPLE_BITS:0]           y_hi;

    // operand select for the current term
    always_comb begin
        case (i_ctrl.term)
            2'd0: begin
                // feedback pass has no w term; keep a not yet computed w out of the sum
                v_sel = i_ctrl.phase_y ? i_w : '0;
                dig   = r_sh[0][COEF_W-1 -: DIG_W];
            end
            2'd1: begin
                v_sel = i_d1;
                dig   = r_sh[1][COEF_W-1 -: DIG_W];
            end
            default: begin
                v_sel = i_d2;
                dig   = r_sh[2][COEF_W-1 -: DIG_W];
            end
        endcase
    end

    // top digit of a coefficient carries the sign
    assign dig5     = i_ctrl.msd ? $signed({dig[DIG_W-1], dig}) : $signed({1'b0, dig});
    assign prod     = v_sel * dig5;
    assign prod_ext = ACC_W'(prod);
    assign acc_base = (i_ctrl.term == '0) ? (r_acc <<< DIG_W) : r_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.load) begin
            n_acc = '0;
        end else if (i_ctrl.step) begin
            n_acc = i_ctrl.phase_y ? (acc_base + prod_ext) : (acc_base - prod_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_ctrl.load) begin
            r_sh[0] <= i_ctrl.phase_y ? i_ff_coef0 : '0;
            r_sh[1] <= i_ctrl.phase_y ? i_ff_coef1 : i_fb_coef1;
            r_sh[2] <= i_ctrl.phase_y ? i_ff_coef2 : i_fb_coef2;
        end else if (i_ctrl.step && (i_ctrl.term == LAST_TERM)) begin
            for (int k = 0; k < NUM_TERMS; k++) begin
                r_sh[k] <= r_sh[k] << DIG_W;
            end
        end
    end

    // w: add x term and rounding half in one go (bits never overlap)
    assign t_w  = r_acc + ((ACC_W'(i_x) <<< YSH) | (ACC_W'(1) << (COEF_FRAC_BITS - 1)));
    assign w_hi = t_w[ACC_W-1 : COEF_FRAC_BITS+STATE_BITS-1];

    always_comb begin
        o_w_clip = !((&w_hi) || !(|w_hi));
        if (!o_w_clip) begin
            o_w = t_w[COEF_FRAC_BITS+STATE_BITS-1 : COEF_FRAC_BITS];
        end else if (t_w[ACC_W-1]) begin
            o_w = {1'b1, {(STATE_BITS-1){1'b0}}};
        end else begin
            o_w = {1'b0, {(STATE_BITS-1){1'b1}}};
        end
    end

    // y: round half up by YSH bits, saturate to sample range
    assign t_y  = r_acc + (ACC_W'(1) << (YSH - 1));
    assign y_hi = t_y[ACC_W-1 : YSH+SAMPLE_BITS-1];

    always_comb begin
        o_y_clip = !((&y_hi) || !(|y_hi));
        if (!o_y_clip) begin
            o_y = t_y[YSH+SAMPLE_BITS-1 : YSH];
        end else if (t_y[ACC_W-1]) begin
            o_y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            o_y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

endmodule

### src/lsbq_ctrl.sv
module lsbq_ctrl
    import lsbq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_free,
    output logic      o_in_ready,
    output t_mac_ctrl o_mac
);

    t_state                r_state;
    t_state                n_state;
    logic [TERM_W-1:0]     r_term;
    logic [TERM_W-1:0]     n_term;
    logic [DIG_CNT_W-1:0]  r_dig;
    logic [DIG_CNT_W-1:0]  n_dig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_term  <= '0;
            r_dig   <= '0;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
            r_dig   <= n_dig;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_term     = r_term;
        n_dig      = r_dig;
        o_in_ready = 1'b0;
        o_mac      = '0;
        o_mac.term = r_term;
        o_mac.msd  = (r_dig == '0);

        unique case (r_state) inside
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_mac.load = 1'b1;
                    n_term     = '0;
                    n_dig      = '0;
                    n_state    = ST_MAC_W;
                end
            end
            ST_MAC_W, ST_MAC_Y: begin
                o_mac.step    = 1'b1;
                o_mac.phase_y = (r_state == ST_MAC_Y);
                if (r_term == LAST_TERM) begin
                    n_term = '0;
                    n_dig  = DIG_CNT_W'(r_dig + 1'b1);
                    if (r_dig == LAST_DIG) begin
                        n_state = (r_state == ST_MAC_Y) ? ST_FIN_Y : ST_FIN_W;
                    end
                end else begin
                    n_term = TERM_W'(r_term + 1'b1);
                end
            end
            ST_FIN_W: begin
                o_mac.fin_w   = 1'b1;
                o_mac.load    = 1'b1;
                o_mac.phase_y = 1'b1;
                n_term        = '0;
                n_dig         = '0;
                n_state       = ST_MAC_Y;
            end
            ST_FIN_Y: begin
                o_mac.phase_y = 1'b1;
                if (i_out_free) begin
                    o_mac.fin_y = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### src/low_shelf_biquad_filter_core.sv
// Low-shelf biquad, direct form II, fixed point.
// Input channel i_in: one signed sample per item. Output channel o_out: the
// filtered sample plus a clip flag (set when w or y saturated for that item).
// Coefficients b0, b1, b2, a1, a2 (signed, COEF_FRAC_BITS fraction bits) are
// written through i_cfg_we / i_cfg_idx / i_cfg_data, by the user only while
// the block is idle (the block does not enforce this); indexes past the last one are ignored.
// Schedule: one shared 4-bit-digit multiplier walks the 8 coefficient digits of
// 3 product terms per pass, for two passes (feedback, then feedforward) with a
// round/saturate step after each. The next item is accepted only once the
// block is back in idle, after the final round step of the previous item.
// Stall: the output register holds its item until taken. Meanwhile a new item
// is accepted and computed; it waits in the final round step until the output
// register frees up, and no further item is accepted until then.
// Reset (i_rst_n low, synchronous): delay line cleared, b0 = 1.0, other
// coefficients zero, output empty, block idle.
module low_shelf_biquad_filter_core
    import lsbq_pkg::*;
#(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28,
    parameter int STATE_BITS     = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lsbq_in_if.sink              i_in,
    lsbq_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data
);

    // coefficient registers
    logic [COEF_W-1:0] r_ff_coef0;
    logic [COEF_W-1:0] r_ff_coef1;
    logic [COEF_W-1:0] r_ff_coef2;
    logic [COEF_W-1:0] r_fb_coef1;
    logic [COEF_W-1:0] r_fb_coef2;

    // filter state: w1, w2 and the new w of the item in flight
    logic signed [STATE_BITS-1:0]  r_d1;
    logic signed [STATE_BITS-1:0]  r_d2;
    logic signed [STATE_BITS-1:0]  r_w;
    logic                          r_w_clip;
    logic signed [SAMPLE_BITS-1:0] r_x;

    // output register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_clip;

    t_mac_ctrl                     mac_ctrl;
    logic                          in_ready;
    logic                          out_free;
    logic signed [STATE_BITS-1:0]  w_rnd;
    logic                          w_clip;
    logic signed [SAMPLE_BITS-1:0] y_rnd;
    logic                          y_clip;

    assign out_free = !r_out_valid || o_out.ready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff_coef0 <= FF_COEF0_RST;
            r_ff_coef1 <= '0;
            r_ff_coef2 <= '0;
            r_fb_coef1 <= '0;
            r_fb_coef2 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FF_COEF0: r_ff_coef0 <= i_cfg_data;
                REG_FF_COEF1: r_ff_coef1 <= i_cfg_data;
                REG_FF_COEF2: r_ff_coef2 <= i_cfg_data;
                REG_FB_COEF1: r_fb_coef1 <= i_cfg_data;
                REG_FB_COEF2: r_fb_coef2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // delay line: shifts once the output of an item is committed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (mac_ctrl.fin_y) begin
            r_d2 <= r_d1;
            r_d1 <= r_w;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_x <= i_in.in_sample;
        end
        if (mac_ctrl.fin_w) begin
            r_w      <= w_rnd;
            r_w_clip <= w_clip;
        end
        if (mac_ctrl.fin_y) begin
            r_out_sample <= y_rnd;
            r_out_clip   <= r_w_clip || y_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (mac_ctrl.fin_y) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    lsbq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (out_free),
        .o_in_ready (in_ready),
        .o_mac      (mac_ctrl)
    );

    lsbq_mac #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .STATE_BITS     (STATE_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_ctrl     (mac_ctrl),
        .i_ff_coef0 (r_ff_coef0),
        .i_ff_coef1 (r_ff_coef1),
        .i_ff_coef2 (r_ff_coef2),
        .i_fb_coef1 (r_fb_coef1),
        .i_fb_coef2 (r_fb_coef2),
        .i_x        (r_x),
        .i_w        (r_w),
        .i_d1       (r_d1),
        .i_d2       (r_d2),
        .o_w        (w_rnd),
        .o_w_clip   (w_clip),
        .o_y        (y_rnd),
        .o_y_clip   (y_clip)
    );

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.out_sample = r_out_sample;
    assign o_out.clipped    = r_out_clip;

    // a new output only appears through the final round step
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(mac_ctrl.fin_y))
        else $error("output valid rose without a final round step");

    // final round never overwrites an untaken item
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_ctrl.fin_y |-> (!r_out_valid || o_out.ready))
        else $error("output register overwritten while stalled");

    // after an item is accepted, the block is busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && in_ready) |=> !in_ready)
        else $error("input accepted while previous item in flight");

    // the two passes never overlap a load with a multiply step
    a_load_step_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_ctrl.step |-> !(mac_ctrl.load || mac_ctrl.fin_w || mac_ctrl.fin_y))
        else $error("multiply step collides with load or round");

endmodule
